### rtl/sobel_3x3_edge_magnitude_defines.svh
// assertion macros for the sobel edge block
// all of them sample on clk and are held off while rst_n is low
`ifndef SOBEL_3X3_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_3X3_EDGE_MAGNITUDE_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every edge
`define SOBEL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define SOBEL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SOBEL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SOBEL_ASSERT(lbl, prop, msg)
`define SOBEL_ASSERT_IMPL(lbl, ante, cons, msg)
`define SOBEL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/sobel_pkg.sv
`default_nettype none

package sobel_pkg;

    localparam int SOBEL_MAX_WIDTH  = 1024;
    localparam int SOBEL_MAX_HEIGHT = 4096;

    localparam int PIX_W          = 8;
    localparam int COL_OUT_W      = 10;
    localparam int ROW_OUT_W      = 12;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int GRAD_W         = 12;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [GRAD_W-1:0] MAG_MAX = 12'd255;

    typedef logic [PIX_W-1:0] pix_t;

    // 3x3 neighborhood, [row][col]
    typedef logic [2:0][2:0][PIX_W-1:0] win3_t;

    typedef struct packed {
        pix_t pixel;
    } pixel_req_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] out_col;
        logic [ROW_OUT_W-1:0] out_row;
        pix_t                 grad_x_mag;
        pix_t                 grad_y_mag;
        logic                 frame_done;
        logic                 run_last;
    } result_t;

    typedef struct packed {
        pix_t gx_mag;
        pix_t gy_mag;
    } sobel_grad_t;

    function automatic logic signed [GRAD_W-1:0] pix_ext(input pix_t p);
        return signed'({{(GRAD_W-PIX_W){1'b0}}, p});
    endfunction

    function automatic pix_t abs_clamp(input logic signed [GRAD_W-1:0] v);
        logic [GRAD_W-1:0] a;
        a = v[GRAD_W-1] ? unsigned'(-v) : unsigned'(v);
        return (a > MAG_MAX) ? MAG_MAX[PIX_W-1:0] : a[PIX_W-1:0];
    endfunction

    // horizontal and vertical sobel sums, magnitude clamped after the full sum
    function automatic sobel_grad_t sobel_3x3(input win3_t a);
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        sobel_grad_t              g;
        gx = (pix_ext(a[0][2]) - pix_ext(a[0][0]))
           + ((pix_ext(a[1][2]) - pix_ext(a[1][0])) <<< 1)
           + (pix_ext(a[2][2]) - pix_ext(a[2][0]));
        gy = (pix_ext(a[2][0]) - pix_ext(a[0][0]))
           + ((pix_ext(a[2][1]) - pix_ext(a[0][1])) <<< 1)
           + (pix_ext(a[2][2]) - pix_ext(a[0][2]));
        g.gx_mag = abs_clamp(gx);
        g.gy_mag = abs_clamp(gy);
        return g;
    endfunction

endpackage

`default_nettype wire

### rtl/sobel_stream_if.sv
`default_nettype none

interface sobel_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

`default_nettype wire

### rtl/sobel_3x3_edge_magnitude.sv
`default_nettype none

// streaming 3x3 sobel edge detector. pixels of a frame_width x frame_height
// frame come in raster order on pix, one request per pixel, and can be taken
// every clock while the result bank is empty or drains. each result on res
// carries its column and row, |Gx| and |Gy| clamped to 255, frame_done on the
// bottom-right pixel and run_last on the last result caused by one pixel.
// neighbors outside the frame count as zero. the result for (x,y) is sent
// once pixel (min(x+1,W-1),min(y+1,H-1)) is in, so one pixel causes zero to
// four results, in raster order. the result bank hands out one result per
// clock while res is ready; a pixel waits in the input stage register until
// the bank has sent all results of the pixel before it, and its own results
// are then registered into the bank and valid on res. the two line buffers
// share one memory, MAX_WIDTH deep and 16 bits wide, one read and one write
// per clock; its content after reset is never used, so there is no clearing
// pass. a write to frame_width or frame_height restarts the frame at (0,0);
// write them only while idle. a width or height of zero acts as one, larger
// values saturate at MAX_WIDTH and MAX_HEIGHT.

`include "sobel_3x3_edge_magnitude_defines.svh"

module sobel_3x3_edge_magnitude
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH  = SOBEL_MAX_WIDTH,
    parameter int MAX_HEIGHT = SOBEL_MAX_HEIGHT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sobel_stream_if.sink          pix,
    sobel_stream_if.source        res
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int NSLOT = 4;
    localparam int LB_W = 2 * PIX_W;

    // configuration
    logic [FRAME_WIDTH_W-1:0]  width_reg;
    logic [FRAME_HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]             last_col;
    logic [RW-1:0]             last_row;
    logic                      cfg_hit;

    // position of the next pixel
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    // input stage
    logic          pix_fire;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          s1_adv;
    pix_t          s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;

    // line buffer memory: upper row in the high byte, lower row in the low byte
    logic [LB_W-1:0] line_mem [MAX_WIDTH];
    logic [LB_W-1:0] rd_data_reg;
    logic [LB_W-1:0] fwd_data_reg;
    logic            fwd_hit_reg;
    logic            fwd_hit_next;
    logic [LB_W-1:0] lb_word;
    logic [LB_W-1:0] lb_wr_data;
    pix_t            up_pix;
    pix_t            lo_pix;

    // two previous columns: [0..2] col c-1, [3..5] col c-2, rows r-2, r-1, r
    pix_t [5:0] win_reg;

    // 4x4 neighborhood rows r-2..r+1, cols c-2..c+1, masked to the frame
    logic [3:0][3:0][PIX_W-1:0] grid;
    logic                       row0_ok;
    logic                       row1_ok;
    logic                       col0_ok;
    logic                       col1_ok;

    // result slots in raster order: (r-1,c-1) (r-1,c) (r,c-1) (r,c)
    win3_t             slot_win  [NSLOT];
    sobel_grad_t       slot_grad [NSLOT];
    logic [CW-1:0]     slot_col  [NSLOT];
    logic [RW-1:0]     slot_row  [NSLOT];
    result_t           slot_data [NSLOT];
    logic [NSLOT-1:0]  slot_mask;
    result_t           slot_reg  [NSLOT];
    logic [NSLOT-1:0]  pend_reg;
    logic [NSLOT-1:0]  pend_next;
    logic [NSLOT-1:0]  pend_after;
    logic [1:0]        sel;
    logic              only_one;
    logic              res_fire;

    // ------------------------------------------------------------------
    // configuration limits
    // ------------------------------------------------------------------
    always_comb
    begin
        if (width_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            last_col = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = CW'(width_reg - 1'b1);
        end

        if (height_reg == '0)
        begin
            last_row = '0;
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            last_row = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            last_row = RW'(height_reg - 1'b1);
        end
    end

    assign cfg_hit = cfg_write_en &&
                     (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RESET;
            height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    width_reg <= cfg_data[FRAME_WIDTH_W-1:0];
                end
                CFG_FRAME_HEIGHT:
                begin
                    height_reg <= cfg_data[FRAME_HEIGHT_W-1:0];
                end
                default:
                begin
                    // unknown index, nothing to write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pixel position counters, raster order, wrap at frame end
    // ------------------------------------------------------------------
    assign pix_fire = pix.valid && pix.ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (pix_fire)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // input stage: pixel register plus line buffer read
    // ------------------------------------------------------------------
    // the stage moves on once the result bank is empty or drains this cycle
    assign s1_adv    = s1_valid_reg && (pend_after == '0);
    assign pix.ready = !s1_valid_reg || s1_adv;

    assign s1_valid_next = pix_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    // a one-pixel-wide frame reads the column being written this cycle
    assign fwd_hit_next = s1_adv && (s1_col_reg == col_reg);

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_pix_reg   <= pix.data.pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            rd_data_reg  <= line_mem[col_reg];
            fwd_data_reg <= lb_wr_data;
        end
        if (s1_adv)
        begin
            line_mem[s1_col_reg] <= lb_wr_data;
        end
    end

    assign lb_word    = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign up_pix     = lb_word[LB_W-1:PIX_W];
    assign lo_pix     = lb_word[PIX_W-1:0];
    // each row moves up one buffer
    assign lb_wr_data = {lo_pix, s1_pix_reg};

    // ------------------------------------------------------------------
    // neighborhood and sobel sums for the four candidate results
    // ------------------------------------------------------------------
    assign row0_ok = 32'(s1_row_reg) >= 2;
    assign row1_ok = s1_row_reg != '0;
    assign col0_ok = 32'(s1_col_reg) >= 2;
    assign col1_ok = s1_col_reg != '0;

    always_comb
    begin
        // row below the current one and column right of it stay zero
        grid       = '0;
        grid[0][0] = (row0_ok && col0_ok) ? win_reg[3] : '0;
        grid[0][1] = (row0_ok && col1_ok) ? win_reg[0] : '0;
        grid[0][2] = row0_ok ? up_pix : '0;
        grid[1][0] = (row1_ok && col0_ok) ? win_reg[4] : '0;
        grid[1][1] = (row1_ok && col1_ok) ? win_reg[1] : '0;
        grid[1][2] = row1_ok ? lo_pix : '0;
        grid[2][0] = col0_ok ? win_reg[5] : '0;
        grid[2][1] = col1_ok ? win_reg[2] : '0;
        grid[2][2] = s1_pix_reg;
    end

    always_comb
    begin
        for (int k = 0; k < NSLOT; k++)
        begin
            for (int rr = 0; rr < 3; rr++)
            begin
                for (int cc = 0; cc < 3; cc++)
                begin
                    slot_win[k][rr][cc] = grid[(k >> 1) + rr][(k & 1) + cc];
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NSLOT; k++)
        begin
            slot_col[k]  = ((k & 1) != 0) ? s1_col_reg : s1_col_reg - 1'b1;
            slot_row[k]  = ((k >> 1) != 0) ? s1_row_reg : s1_row_reg - 1'b1;
            slot_grad[k] = sobel_3x3(slot_win[k]);

            slot_data[k].out_col    = COL_OUT_W'(slot_col[k]);
            slot_data[k].out_row    = ROW_OUT_W'(slot_row[k]);
            slot_data[k].grad_x_mag = slot_grad[k].gx_mag;
            slot_data[k].grad_y_mag = slot_grad[k].gy_mag;
            slot_data[k].frame_done = (slot_col[k] == last_col) &&
                                      (slot_row[k] == last_row);
            slot_data[k].run_last   = 1'b0;
        end
    end

    // a row is finished by the pixel below it, or at once on the last row
    assign slot_mask[0] = row1_ok && col1_ok;
    assign slot_mask[1] = row1_ok && (s1_col_reg == last_col);
    assign slot_mask[2] = (s1_row_reg == last_row) && col1_ok;
    assign slot_mask[3] = (s1_row_reg == last_row) && (s1_col_reg == last_col);

    // ------------------------------------------------------------------
    // result bank: up to four results, sent lowest slot first
    // ------------------------------------------------------------------
    always_comb
    begin
        priority if (pend_reg[0])
        begin
            sel = 2'd0;
        end
        else if (pend_reg[1])
        begin
            sel = 2'd1;
        end
        else if (pend_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
    end

    assign only_one  = (pend_reg & (pend_reg - 1'b1)) == '0;
    assign res.valid = pend_reg != '0;
    assign res_fire  = res.valid && res.ready;

    always_comb
    begin
        res.data          = slot_reg[sel];
        res.data.run_last = only_one;
    end

    // clearing the lowest set bit drops the result just sent
    assign pend_after = res_fire ? (pend_reg & (pend_reg - 1'b1)) : pend_reg;
    assign pend_next  = s1_adv ? slot_mask : pend_after;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            for (int k = 0; k < NSLOT; k++)
            begin
                slot_reg[k] <= slot_data[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            win_reg      <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            pend_reg     <= pend_next;
            if (pix_fire)
            begin
                fwd_hit_reg <= fwd_hit_next;
            end
            if (s1_adv)
            begin
                win_reg[3] <= win_reg[0];
                win_reg[4] <= win_reg[1];
                win_reg[5] <= win_reg[2];
                win_reg[0] <= up_pix;
                win_reg[1] <= lo_pix;
                win_reg[2] <= s1_pix_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SOBEL_ASSERT(a_col_in_frame, col_reg <= last_col, "column counter past frame width")
    `SOBEL_ASSERT(a_row_in_frame, row_reg <= last_row, "row counter past frame height")
    `SOBEL_ASSERT_NEXT(a_bank_drains, res_fire && res.data.run_last && !s1_adv,
                       pend_reg == '0, "result bank not empty after last result")
    `SOBEL_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !s1_adv,
                       s1_valid_reg && $stable(s1_col_reg) && $stable(s1_pix_reg),
                       "stalled pixel lost or changed")

endmodule

`default_nettype wire
